[sv/crc32fc_pkg.sv]
// ----------------------------------------------------------------------------
// crc32fc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the frame
// checker.
// ----------------------------------------------------------------------------
package crc32fc_pkg;

   // crc constants (reflected ieee 802.3)
   localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
   localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

   // byte counter
   localparam int unsigned CountWidth = 7;
   localparam logic [CountWidth-1:0] CountMax = 7'd127;
   localparam logic [CountWidth-1:0] TrailerBytes = 7'd4;

   // configuration
   localparam logic [CountWidth-1:0] FrameLengthReset = 7'd36;
   localparam int MaxFrameDefault = 64;

   // result codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_CRC = 2'd1,
      ST_BAD_LEN = 2'd2
   } status_type;

   // input transfer payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // result transfer payload
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] computed_crc;
      logic [31:0] received_crc;
   } rsp_payload_type;

   // one byte through the reflected crc, bit at a time
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[sv/crc32_frame_checker.sv]
// ----------------------------------------------------------------------------
// crc32_frame_checker
// Per-packet CRC-32 check with trailing little-endian CRC and length check.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one packet byte per transfer, last_byte set on the final
//     byte. The final four bytes are the transmitted CRC, least byte first.
//   rsp_ channel: one result per packet (status, computed and received CRC).
//   csr_ port: write frame_length (bytes including the CRC) while idle.
// Throughput: one byte per cycle while no end-marked byte waits; the input
//   register, the byte CRC update and the result register form a two-stage
//   pipeline; the last byte is registered, then its result is registered.
// Reset: clears the packet state, sets frame_length to 36 and empties both
//   registers; req_ready is high in the first cycle after reset.
// Stall: a waiting result holds its register; further bytes of the next
//   packet keep flowing, and only the next end-marked byte waits in the
//   input register until the result slot frees.
// ----------------------------------------------------------------------------
module crc32_frame_checker #(
   parameter int MaxFrame = crc32fc_pkg::MaxFrameDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [6:0]                    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  crc32fc_pkg::req_payload_type  req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output crc32fc_pkg::rsp_payload_type  rsp_payload
);

   logic                         consume;
   logic                         item_valid;
   crc32fc_pkg::req_payload_type item;
   logic                         out_free;
   logic                         result_load;
   crc32fc_pkg::rsp_payload_type result;

   // input register
   crc32fc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   // crc and length check
   crc32fc_core #(.MaxFrame(MaxFrame)) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .consume    (consume),
      .result_load(result_load),
      .result     (result)
   );

   // result register
   crc32fc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (result_load),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

[sv/crc32fc_in_stage.sv]
// ----------------------------------------------------------------------------
// crc32fc_in_stage
// Input register: holds one accepted byte until the core consumes it.
// ----------------------------------------------------------------------------
module crc32fc_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  crc32fc_pkg::req_payload_type  req_payload,
   input  logic                          consume,
   output logic                          item_valid,
   output crc32fc_pkg::req_payload_type  item
);

   logic                         valid_ff, valid_in;
   crc32fc_pkg::req_payload_type item_ff;

   // free when empty or when the held byte leaves this cycle
   assign req_ready = !valid_ff || consume;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !consume);

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[sv/crc32fc_core.sv]
// ----------------------------------------------------------------------------
// crc32fc_core
// Packet state: trailer delay line, running crc, saturating byte count and
// the end-of-packet check.
// ----------------------------------------------------------------------------
module crc32fc_core #(
   parameter int MaxFrame = crc32fc_pkg::MaxFrameDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [6:0]                    csr_wr_data,
   input  logic                          item_valid,
   input  crc32fc_pkg::req_payload_type  item,
   input  logic                          out_free,
   output logic                          consume,
   output logic                          result_load,
   output crc32fc_pkg::rsp_payload_type  result
);

   logic [6:0]  frame_length_ff;
   logic [31:0] crc_ff, crc_in;
   logic [6:0]  count_ff, count_in;
   logic [31:0] trailer_ff, trailer_in;
   logic [31:0] computed;
   crc32fc_pkg::status_type status;

   // a byte moves on unless it ends a packet and the result slot is full
   assign consume     = item_valid && (!item.last_byte || out_free);
   assign result_load = consume && item.last_byte;

   // frame length register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= crc32fc_pkg::FrameLengthReset;
      end else if (csr_wr_en) begin
         frame_length_ff <= csr_wr_data;
      end
   end

   // oldest trailer byte enters the crc once the delay line is full
   always_comb begin
      crc_in     = (count_ff >= crc32fc_pkg::TrailerBytes)
                   ? crc32fc_pkg::crc32_byte(crc_ff, trailer_ff[7:0]) : crc_ff;
      trailer_in = {item.data_byte, trailer_ff[31:8]};
      count_in   = (count_ff < crc32fc_pkg::CountMax) ? count_ff + 7'd1 : count_ff;
   end

   // end-of-packet check
   always_comb begin
      computed = ~crc_in;
      priority if (count_in != frame_length_ff || count_in < crc32fc_pkg::TrailerBytes
                   || int'(count_in) > MaxFrame) begin
         status = crc32fc_pkg::ST_BAD_LEN;
      end else if (computed != trailer_in) begin
         status = crc32fc_pkg::ST_BAD_CRC;
      end else begin
         status = crc32fc_pkg::ST_OK;
      end
      result.status       = status;
      result.computed_crc = computed;
      result.received_crc = trailer_in;
   end

   // packet state, cleared after the end mark
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= crc32fc_pkg::CrcInit;
         count_ff   <= '0;
         trailer_ff <= '0;
      end else if (consume) begin
         if (item.last_byte) begin
            crc_ff     <= crc32fc_pkg::CrcInit;
            count_ff   <= '0;
            trailer_ff <= '0;
         end else begin
            crc_ff     <= crc_in;
            count_ff   <= count_in;
            trailer_ff <= trailer_in;
         end
      end
   end

endmodule

[sv/crc32fc_out_stage.sv]
// ----------------------------------------------------------------------------
// crc32fc_out_stage
// Result register: holds one packet result until the receiver takes it.
// ----------------------------------------------------------------------------
module crc32fc_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  crc32fc_pkg::rsp_payload_type  result,
   output logic                          out_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output crc32fc_pkg::rsp_payload_type  rsp_payload
);

   logic                         valid_ff, valid_in;
   crc32fc_pkg::rsp_payload_type result_ff;

   // slot is free when empty or being taken this cycle
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = result_ff;

endmodule

[sv/crc32fc_checker.sv]
// ----------------------------------------------------------------------------
// crc32fc_checker
// Port-level checks for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module crc32fc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input crc32fc_pkg::rsp_payload_type  rsp_payload
);

   // a stalled result stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   // reset empties both registers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // an ok status means the two crc values agree
   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == crc32fc_pkg::ST_OK
      |-> rsp_payload.computed_crc == rsp_payload.received_crc)
      else $error("ok status with differing crc values");

endmodule

bind crc32_frame_checker crc32fc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);
